FILE: sv/hsbr_pkg.sv
// Shared constants, types and opcodes for the hue/saturation background removal block.
`timescale 1ns / 1ps

package hsbr_pkg;

   // Histogram geometry.
   localparam int HUE_BINS   = 8;
   localparam int SAT_BINS   = 40;
   localparam int COUNT_BITS = 24;

   // Spans used by the bin mapping.
   localparam int HUE_SPAN        = 180;
   localparam int SAT_LEARN_SPAN  = 255;
   localparam int SAT_FILTER_SPAN = 256;

   localparam int TABLE_SIZE   = HUE_BINS * SAT_BINS;
   localparam int ADDR_BITS    = $clog2(TABLE_SIZE);
   localparam int HUE_BIN_BITS = $clog2(HUE_BINS);
   localparam int SAT_BIN_BITS = $clog2(SAT_BINS);

   // Scaled pixel component (8 bits times at most 64 bins).
   localparam int SCALE_BITS = 16;

   localparam int PIX_BITS  = 8;
   localparam int NORM_BITS = 10;
   localparam logic [NORM_BITS-1:0] NORM_RESET = NORM_BITS'(240);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Item opcodes carried on the input tuser.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LEARN  = 2'd1,
      OP_FILTER = 2'd2
   } op_type;

   // Table lookup produced by the bin mapper.
   typedef struct packed {
      logic                 count_ok;
      logic [ADDR_BITS-1:0] addr;
   } bin_type;

endpackage

FILE: sv/hsbr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module hsbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: sv/hsbr_bin_map.sv
// Maps a hue/saturation pair to a histogram table address.
`timescale 1ns / 1ps

module hsbr_bin_map
   import hsbr_pkg::*;
(
   input  logic                learn_mode,
   input  logic [PIX_BITS-1:0] hue,
   input  logic [PIX_BITS-1:0] sat,
   output bin_type             bin
);

   logic [SCALE_BITS-1:0]   hue_scaled;
   logic [SCALE_BITS-1:0]   sat_scaled;
   logic [HUE_BIN_BITS-1:0] hue_bin;
   logic [SAT_BIN_BITS-1:0] sat_bin;

   assign hue_scaled = SCALE_BITS'(hue) * SCALE_BITS'(HUE_BINS);
   assign sat_scaled = SCALE_BITS'(sat) * SCALE_BITS'(SAT_BINS);

   // The bin is the last threshold k*span that the scaled value reaches.
   // Stopping at the last bin also clamps an out-of-range filter hue.
   always_comb begin
      hue_bin = '0;
      for (int k = 1; k < HUE_BINS; k++) begin
         if (hue_scaled >= SCALE_BITS'(k * HUE_SPAN)) begin
            hue_bin = HUE_BIN_BITS'(k);
         end
      end
   end

   // Learning divides saturation by 255, filtering by 256.
   always_comb begin
      sat_bin = '0;
      for (int k = 1; k < SAT_BINS; k++) begin
         if (learn_mode) begin
            if (sat_scaled >= SCALE_BITS'(k * SAT_LEARN_SPAN)) begin
               sat_bin = SAT_BIN_BITS'(k);
            end
         end else begin
            if (sat_scaled >= SCALE_BITS'(k * SAT_FILTER_SPAN)) begin
               sat_bin = SAT_BIN_BITS'(k);
            end
         end
      end
   end

   // Out-of-range hue and saturation at its top are not counted when learning.
   assign bin.count_ok = (hue < PIX_BITS'(HUE_SPAN)) && (sat != {PIX_BITS{1'b1}});
   assign bin.addr     = ADDR_BITS'(ADDR_BITS'(hue_bin) * ADDR_BITS'(SAT_BINS))
                       + ADDR_BITS'(sat_bin);

endmodule

FILE: sv/hue_sat_histogram_background_removal_core.sv
// Top level of the hue/saturation histogram background removal block.
`timescale 1ns / 1ps

// Usage
// -----
// req_* carries one pixel per transfer: tuser holds the opcode (clear, learn,
// filter) and tdata holds hue, saturation and value. Only a filter item gives a
// result on rsp_*: tdata holds the (possibly zeroed) pixel, tuser the removed flag.
// csr_* writes the normalization height; write it only while the block is idle.
// The histogram lives in one RAM with a registered read. A learn item reads, then
// writes back the saturating count; a filter item reads, scales by the height and
// compares with the running maximum, and its result is registered on rsp_*. An
// ignored opcode is taken without effect. A clear item sweeps the RAM one entry a
// cycle, so req_tready stays low until all 320 entries are cleared. Reset starts
// the same clearing sweep.
// The result sits in an output register, so the next item is taken while a
// result waits; a filter item that finishes while that register is still full
// holds in its compare step until rsp_tready frees the register.
module hue_sat_histogram_background_removal_core
   import hsbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,  // hue [7:0], sat [15:8], val [23:16]
   input  logic [1:0]           req_tuser,  // opcode [1:0]
   // Result stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // out_hue [7:0], out_sat [15:8], out_val [23:16]
   output logic                 rsp_tuser,  // removed [0]
   // Configuration write.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [NORM_BITS-1:0] csr_data    // norm_height
);

   localparam int PROD_BITS = COUNT_BITS + 1 + NORM_BITS;
   localparam int DATA_BITS = 3 * PIX_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_TEST
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [COUNT_BITS-1:0] max_ff, max_in;
   logic [NORM_BITS-1:0]  norm_ff;
   op_type                op_ff, op_in;
   logic                  count_ok_ff, count_ok_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [DATA_BITS-1:0]  pixel_ff, pixel_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                  zero_ff, zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_removed_ff, rsp_removed_in;

   logic                  req_xfer;
   op_type                req_op;
   bin_type               bin;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic [COUNT_BITS-1:0] count_next;
   logic                  removed;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_removed_ff;

   // Table address of the incoming pixel.
   hsbr_bin_map u_bin_map (
      .learn_mode (req_op == OP_LEARN),
      .hue        (req_tdata[PIX_BITS-1:0]),
      .sat        (req_tdata[2*PIX_BITS-1:PIX_BITS]),
      .bin        (bin)
   );

   // Saturating increment of the count read back from the table.
   assign count_next = (ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + 1'b1;

   // The clearing sweep and the learn write-back share the write port.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = count_next;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_UPDATE && op_ff == OP_LEARN && count_ok_ff) begin
         ram_wr_en = 1'b1;
      end
   end

   hsbr_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_xfer),
      .rd_addr (bin.addr),
      .rd_data (ram_rd_data)
   );

   // A populated bin matches when 2*count*height reaches the running maximum.
   assign removed = !zero_ff && (prod_ff >= PROD_BITS'(max_ff));

   // Sequencer: clearing sweep, accept, read-modify-write and result compare.
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      max_in         = max_ff;
      op_in          = op_ff;
      count_ok_in    = count_ok_ff;
      addr_in        = addr_ff;
      pixel_in       = pixel_ff;
      prod_in        = prod_ff;
      zero_in        = zero_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_removed_in = rsp_removed_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(TABLE_SIZE - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in       = req_op;
               count_ok_in = bin.count_ok;
               addr_in     = bin.addr;
               pixel_in    = req_tdata;
               unique case (req_op)
                  OP_CLEAR: begin
                     max_in      = '0;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  OP_LEARN, OP_FILTER: begin
                     state_in = ST_UPDATE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            if (op_ff == OP_LEARN) begin
               if (count_ok_ff && count_next > max_ff) begin
                  max_in = count_next;
               end
               state_in = ST_IDLE;
            end else begin
               prod_in  = PROD_BITS'({ram_rd_data, 1'b0}) * PROD_BITS'(norm_ff);
               zero_in  = (ram_rd_data == '0);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = removed ? '0 : pixel_ff;
               rsp_removed_in = removed;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         max_ff       <= '0;
         norm_ff      <= NORM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            norm_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      count_ok_ff    <= count_ok_in;
      addr_ff        <= addr_in;
      pixel_ff       <= pixel_in;
      prod_ff        <= prod_in;
      zero_ff        <= zero_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   // A table read never overlaps a write in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && req_xfer))
      else $error("table read and write in the same cycle");

   // The running maximum only falls when a clear item is taken.
   a_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_xfer && req_op == OP_CLEAR) |=> max_ff >= $past(max_ff))
      else $error("running maximum decreased without a clear");

   // A learn write-back always stores a nonzero count.
   a_learn_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == ST_UPDATE) |-> ram_wr_data != '0)
      else $error("learn write-back stored a zero count");

   // The clearing sweep ends in idle after the last entry.
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_addr_ff == ADDR_BITS'(TABLE_SIZE - 1))
      |=> state_ff == ST_IDLE)
      else $error("clearing sweep did not end after the last entry");

endmodule

FILE: tb/sv/tb_hue_sat_histogram_background_removal_core.sv
// Self-checking testbench for the hue/saturation histogram background removal core.
`timescale 1ns / 1ps

module tb_hue_sat_histogram_background_removal_core;
   import hsbr_pkg::*;

   // Opcode that the block ignores.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // Idle time before a register write covers a clearing sweep plus the pipeline.
   localparam int IDLE_GAP    = 400;
   localparam int DRAIN_TAIL  = 16;
   localparam int CYCLE_LIMIT = 400000;

   // One filtered pixel as it leaves the block.
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      logic       removed;
   } pixel_result_type;

   // Keeps its own copy of the histogram and the queue of expected pixels.
   class hsv_mask_scoreboard;
      logic [COUNT_BITS-1:0] bin_counts [TABLE_SIZE];
      logic [COUNT_BITS-1:0] max_count;
      logic [NORM_BITS-1:0]  norm_height;
      pixel_result_type      expected_pixels [$];
      int                    mismatches;

      function new();
         clear_counts();
         norm_height = NORM_RESET;
         mismatches  = 0;
      endfunction

      function void clear_counts();
         foreach (bin_counts[i]) bin_counts[i] = '0;
         max_count = '0;
      endfunction

      function void set_height(logic [NORM_BITS-1:0] height);
         norm_height = height;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Apply one accepted input transfer to the histogram and predict its result.
      function void note_item(logic [1:0] op, logic [7:0] h, logic [7:0] s, logic [7:0] v);
         int                hb;
         int                sb;
         int                idx;
         logic [63:0]       scaled;
         pixel_result_type  res;
         case (op)
            OP_CLEAR: begin
               clear_counts();
            end
            OP_LEARN: begin
               // Out-of-range hue and the top saturation are not counted.
               if (h < HUE_SPAN && s < SAT_LEARN_SPAN) begin
                  hb  = int'(h) * HUE_BINS / HUE_SPAN;
                  sb  = int'(s) * SAT_BINS / SAT_LEARN_SPAN;
                  idx = hb * SAT_BINS + sb;
                  if (bin_counts[idx] != COUNT_MAX) bin_counts[idx] = bin_counts[idx] + 1'b1;
                  if (bin_counts[idx] > max_count) max_count = bin_counts[idx];
               end
            end
            OP_FILTER: begin
               hb = int'(h) * HUE_BINS / HUE_SPAN;
               if (hb > HUE_BINS - 1) hb = HUE_BINS - 1;
               sb = int'(s) * SAT_BINS / SAT_FILTER_SPAN;
               if (sb > SAT_BINS - 1) sb = SAT_BINS - 1;
               idx    = hb * SAT_BINS + sb;
               scaled = 64'(bin_counts[idx]) * 64'(norm_height) * 64'd2;
               if (bin_counts[idx] != '0 && scaled >= 64'(max_count)) begin
                  res = '{hue: 8'd0, sat: 8'd0, val: 8'd0, removed: 1'b1};
               end else begin
                  res = '{hue: h, sat: s, val: v, removed: 1'b0};
               end
               expected_pixels.push_back(res);
            end
            default: begin
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one accepted result transfer with the oldest expectation.
      task check_result(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic rm);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d/%0d/%0d with nothing expected",
                                      h, s, v, rm));
         end else begin
            want = expected_pixels.pop_front();
            if (h !== want.hue)
               report_mismatch($sformatf("out_hue got %0d expected %0d", h, want.hue));
            if (s !== want.sat)
               report_mismatch($sformatf("out_sat got %0d expected %0d", s, want.sat));
            if (v !== want.val)
               report_mismatch($sformatf("out_val got %0d expected %0d", v, want.val));
            if (rm !== want.removed)
               report_mismatch($sformatf("removed got %0d expected %0d", rm, want.removed));
         end
      endtask
   endclass

   // Block inputs start at known values.
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata  = '0;  // hue [7:0], sat [15:8], val [23:16]
   logic [1:0]           req_tuser  = OP_CLEAR;  // opcode [1:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;  // out_hue [7:0], out_sat [15:8], out_val [23:16]
   logic                 rsp_tuser;  // removed [0]
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [NORM_BITS-1:0] csr_data   = '0;  // norm_height

   hsv_mask_scoreboard sb;
   int                 burst_left = 0;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   int                 stall_mode = 0;
   int                 stall_phase = 0;

   hue_sat_histogram_background_removal_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch every transfer and feed the scoreboard in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_item(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (csr_valid && csr_ready)
            sb.set_height(csr_data);
      end
   end

   // The result side stalls in randomly chosen modes, each held for a random span.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (stall_phase % 7) < 4;
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hue_sat_histogram_background_removal_core");
         $finish;
      end
   end

   // Offer one pixel, in bursts separated by random gaps, and wait for its transfer.
   task automatic send_pixel(logic [1:0] op, logic [7:0] h, logic [7:0] s, logic [7:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, s, h};
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Let every expected pixel arrive and any clearing sweep finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_height(logic [NORM_BITS-1:0] height);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // A value near a center, held inside [0, top].
   function automatic logic [7:0] near(int center, int spread, int top);
      int x;
      x = center + $urandom_range(0, 2 * spread) - spread;
      if (x < 0) x = 0;
      if (x > top) x = top;
      return 8'(x);
   endfunction

   // Edges of the bin mapping, ignored items and the empty table.
   task automatic run_directed();
      send_pixel(OP_FILTER, 8'd0, 8'd0, 8'd0);        // empty table keeps the pixel
      send_pixel(OP_FILTER, 8'd255, 8'd255, 8'd255);
      send_pixel(OP_LEARN, 8'd0, 8'd0, 8'd17);
      send_pixel(OP_LEARN, 8'd179, 8'd254, 8'd255);   // last hue and saturation bins
      send_pixel(OP_LEARN, 8'd180, 8'd10, 8'd0);      // hue out of range, not counted
      send_pixel(OP_LEARN, 8'd255, 8'd10, 8'd0);
      send_pixel(OP_LEARN, 8'd50, 8'd255, 8'd0);      // top saturation, not counted
      send_pixel(OP_IGNORED, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_FILTER, 8'd0, 8'd0, 8'h80);
      send_pixel(OP_FILTER, 8'd179, 8'd255, 8'hff);
      send_pixel(OP_FILTER, 8'd255, 8'd255, 8'h7f);   // hue bin clamped to the last
      send_pixel(OP_FILTER, 8'd180, 8'd0, 8'h01);
      send_pixel(OP_FILTER, 8'd50, 8'd255, 8'h02);
      send_pixel(OP_FILTER, 8'd200, 8'd10, 8'h03);
      send_pixel(OP_IGNORED, 8'd179, 8'd254, 8'hff);
      send_pixel(OP_LEARN, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_LEARN, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_LEARN, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_FILTER, 8'd179, 8'd254, 8'h5a);
      send_pixel(OP_FILTER, 8'd1, 8'd3, 8'ha5);
      send_pixel(OP_CLEAR, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_FILTER, 8'd0, 8'd0, 8'h55);       // cleared table keeps the pixel
      send_pixel(OP_FILTER, 8'd179, 8'd254, 8'haa);
   endtask

   // One setting of the height: clear, learn three background colors, then mostly filter.
   task automatic run_phase(logic [NORM_BITS-1:0] height);
      int center_h [3];
      int center_s [3];
      int c;
      int pick;
      int r;
      write_height(height);
      send_pixel(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      for (int k = 0; k < 3; k++) begin
         center_h[k] = $urandom_range(0, 179);
         center_s[k] = $urandom_range(0, 254);
      end
      for (int i = 0; i < 100; i++) begin
         pick = $urandom_range(0, 99);
         r    = $urandom_range(0, 9);
         c    = (r < 6) ? 0 : (r < 9) ? 1 : 2;
         if (pick < 3) begin
            send_pixel(OP_IGNORED, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 7) begin
            // Learn items that must not be counted.
            if (pick < 5)
               send_pixel(OP_LEARN, 8'($urandom_range(180, 255)), 8'($urandom),
                          8'($urandom));
            else
               send_pixel(OP_LEARN, 8'($urandom), 8'd255, 8'($urandom));
         end else if (i < 45 || pick < 20) begin
            send_pixel(OP_LEARN, near(center_h[c], 6, 179), near(center_s[c], 4, 254),
                       8'($urandom));
         end else if (pick < 21) begin
            send_pixel(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 70) begin
            send_pixel(OP_FILTER, near(center_h[c], 10, 255), near(center_s[c], 8, 255),
                       8'($urandom));
         end else begin
            send_pixel(OP_FILTER, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      logic [NORM_BITS-1:0] heights [7];
      sb = new();
      heights = '{10'd1, 10'd1023, 10'd0, 10'd240, 10'd2, 10'd0, 10'd0};
      heights[5] = 10'($urandom_range(1, 1023));
      heights[6] = 10'($urandom_range(3, 64));

      // Single reset at the start of the run.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      foreach (heights[p]) run_phase(heights[p]);

      // Drain the remaining results.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pending()));

      if (sb.mismatches == 0) begin
         $display("PASS hue_sat_histogram_background_removal_core");
      end else begin
         $display("FAIL hue_sat_histogram_background_removal_core");
      end
      $finish;
   end

endmodule
